FILE: design/pol_pkg.sv
// Package for the positional ordered list: sizes, operation and status codes,
// and the command word passed from the front end to the back end.
// Used by every module of the block; depends on nothing.
package pol_pkg;

   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = ($clog2(DEPTH + 1) > 6) ? $clog2(DEPTH + 1) : 6;
   localparam int VALUE_W = 32;
   localparam int LOC_W = 6;
   localparam int STATUS_W = 2;
   localparam int ENTRY_COUNT_W = 6;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADLOC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_DELETE,
      KIND_ERROR
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } state_type;

   typedef struct packed {
      kind_type kind;
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0] pos;
      logic signed [VALUE_W-1:0] value;
      logic [CNT_W-1:0] count;
   } cmd_type;

endpackage

FILE: design/pol_front.sv
// Front end of the positional ordered list: checks each incoming word against
// its own copy of the entry count and turns it into a command for the back end.
// Depends on pol_pkg.
module pol_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_opcode,
   input  logic signed [pol_pkg::VALUE_W-1:0] req_value,
   input  logic [pol_pkg::LOC_W-1:0]     req_location,
   input  logic                          req_place_after,
   input  logic                          q_full,
   output logic                          q_push,
   output pol_pkg::cmd_type              q_cmd
);
   import pol_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] loc_ext;
   logic loc_bad;
   cmd_type cmd;

   assign loc_ext = CNT_W'(req_location);
   assign loc_bad = (loc_ext == '0) || (loc_ext > count_ff);

   // The count only changes on a successful command, so the front end can
   // track it ahead of the back end without waiting for the shift to happen.
   always_comb begin
      cmd.kind = KIND_ERROR;
      cmd.status = STATUS_OK;
      cmd.pos = '0;
      cmd.value = req_value;
      cmd.count = count_ff;
      if (req_opcode == OP_INSERT) begin
         if (count_ff >= CNT_W'(DEPTH)) begin
            cmd.status = STATUS_FULL;
         end else if (count_ff == '0) begin
            cmd.kind = KIND_INSERT;
            cmd.count = count_ff + CNT_W'(1);
         end else if (loc_bad) begin
            cmd.status = STATUS_BADLOC;
         end else begin
            cmd.kind = KIND_INSERT;
            cmd.pos = req_place_after ? IDX_W'(loc_ext) : IDX_W'(loc_ext - CNT_W'(1));
            cmd.count = count_ff + CNT_W'(1);
         end
      end else begin
         if (count_ff == '0) begin
            cmd.status = STATUS_EMPTY;
         end else if (loc_bad) begin
            cmd.status = STATUS_BADLOC;
         end else begin
            cmd.kind = KIND_DELETE;
            cmd.pos = IDX_W'(loc_ext - CNT_W'(1));
            cmd.count = count_ff - CNT_W'(1);
         end
      end
   end

   assign req_full = q_full;
   assign q_push = req_push && !q_full;
   assign q_cmd = cmd;
   assign count_in = q_push ? cmd.count : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/pol_queue.sv
// Short command queue between the front end and the back end of the
// positional ordered list. Depends on pol_pkg.
module pol_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pol_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output pol_pkg::cmd_type pop_cmd,
   output logic             empty
);
   import pol_pkg::*;

   cmd_type slots_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign empty = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (Q_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (Q_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/pol_back.sv
// Back end of the positional ordered list: applies each command to the shifting
// entry array and streams the result words through an output register.
// Depends on pol_pkg.
module pol_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  pol_pkg::cmd_type                   q_cmd,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [pol_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pol_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count,
   output logic                               rsp_entry_valid,
   output logic signed [pol_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic                               rsp_last
);
   import pol_pkg::*;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];

   logic out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [ENTRY_COUNT_W-1:0] out_count_ff, out_count_in;
   logic out_entry_valid_ff, out_entry_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;

   logic emit, single, at_last;

   // Errors and an emptied list give a single word without an entry.
   assign single = (cmd_ff.kind == KIND_ERROR) || (cmd_ff.count == '0);
   assign at_last = single || ((CNT_W'(idx_ff) + CNT_W'(1)) == cmd_ff.count);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_cmd;
               idx_in = '0;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               emit = 1'b1;
               idx_in = idx_ff + IDX_W'(1);
               if (at_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // The whole shift for one command happens in the cycle it leaves the queue.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (q_pop && q_cmd.kind == KIND_INSERT) begin
         for (int i = 1; i < DEPTH; i++) begin
            if (IDX_W'(i) > q_cmd.pos) begin
               entries_in[i] = entries_ff[i - 1];
            end
         end
         entries_in[q_cmd.pos] = q_cmd.value;
      end else if (q_pop && q_cmd.kind == KIND_DELETE) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= q_cmd.pos) begin
               entries_in[i] = entries_ff[i + 1];
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_status_in = out_status_ff;
      out_count_in = out_count_ff;
      out_entry_valid_in = out_entry_valid_ff;
      out_value_in = out_value_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_status_in = cmd_ff.status;
         out_count_in = cmd_ff.count[ENTRY_COUNT_W-1:0];
         out_entry_valid_in = !single;
         out_value_in = single ? '0 : entries_ff[idx_ff];
         out_last_in = at_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      out_status_ff <= out_status_in;
      out_count_ff <= out_count_in;
      out_entry_valid_ff <= out_entry_valid_in;
      out_value_ff <= out_value_in;
      out_last_ff <= out_last_in;
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_entry_valid = out_entry_valid_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_last = out_last_ff;

   // The dump index never runs past the live part of the list.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && !single) |-> (CNT_W'(idx_ff) < cmd_ff.count))
      else $error("dump index beyond entry count");

   // After the final word of a command the sequencer returns to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> (state_ff == BK_IDLE))
      else $error("sequencer did not return to idle after last word");

   // A word is only written into the output register when it is free or drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop && state_ff == BK_EMIT) |=> $stable(out_value_ff))
      else $error("pending result word overwritten");

endmodule

FILE: design/positional_ordered_list_top.sv
// Positional ordered list: an ordered list of signed 32-bit values kept in a
// shifting register array. A request passes the command queue, the back end's
// command register and the output register, then one result word per cycle
// while rsp_pop drains the output; no new command starts before the last word.
// Synchronous active-high reset empties the list and the command queue.
module positional_ordered_list_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_opcode,
   input  logic signed [pol_pkg::VALUE_W-1:0] req_value,
   input  logic [pol_pkg::LOC_W-1:0]          req_location,
   input  logic                               req_place_after,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [pol_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pol_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count,
   output logic                               rsp_entry_valid,
   output logic signed [pol_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic                               rsp_last
);
   import pol_pkg::*;

   logic q_full, q_push, q_pop, q_empty;
   cmd_type push_cmd, pop_cmd;

   pol_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .req_location(req_location),
      .req_place_after(req_place_after),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(push_cmd)
   );

   pol_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(push_cmd),
      .full(q_full),
      .pop(q_pop),
      .pop_cmd(pop_cmd),
      .empty(q_empty)
   );

   pol_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_cmd(pop_cmd),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_entry_value(rsp_entry_value),
      .rsp_last(rsp_last)
   );

endmodule
